// File: hw/rtl/tpc_pkg.sv
// Shared types and constants for the three-point temperature calibration core.
`default_nettype none
package tpc_pkg;

   localparam int DataWidth = 16;
   localparam int RemWidth  = 69;   // 2|N| + |D| fits in 67 bits, kept with margin
   localparam int DvsWidth  = 52;   // 2|D|
   localparam int QuoWidth  = 17;   // sixteen quotient bits and an overflow bit
   localparam int IdxWidth  = 3;

   localparam logic [IdxWidth-1:0] REG_POINT1_RAW = 3'd0;
   localparam logic [IdxWidth-1:0] REG_POINT1_REF = 3'd1;
   localparam logic [IdxWidth-1:0] REG_POINT2_RAW = 3'd2;
   localparam logic [IdxWidth-1:0] REG_POINT2_REF = 3'd3;
   localparam logic [IdxWidth-1:0] REG_POINT3_RAW = 3'd4;
   localparam logic [IdxWidth-1:0] REG_POINT3_REF = 3'd5;

   localparam logic signed [DataWidth-1:0] RESET_POINT1 = 16'sd1000;
   localparam logic signed [DataWidth-1:0] RESET_POINT2 = 16'sd4000;
   localparam logic signed [DataWidth-1:0] RESET_POINT3 = 16'sd8000;

   localparam logic signed [DataWidth-1:0] SAT_MAX = 16'sh7FFF;
   localparam logic signed [DataWidth-1:0] SAT_MIN = 16'sh8000;

   typedef struct packed {
      logic signed [DataWidth-1:0] point1_raw;
      logic signed [DataWidth-1:0] point1_ref;
      logic signed [DataWidth-1:0] point2_raw;
      logic signed [DataWidth-1:0] point2_ref;
      logic signed [DataWidth-1:0] point3_raw;
      logic signed [DataWidth-1:0] point3_ref;
   } cal_type;

   typedef struct packed {
      logic [RemWidth-1:0]  rem;
      logic [DvsWidth-1:0]  dvs;
      logic [QuoWidth-1:0]  quo;
      logic                 neg;
      logic                 pass;
      logic [DataWidth-1:0] raw;
   } div_item_type;

endpackage
`default_nettype wire

// File: hw/rtl/three_point_temperature_calibration_core.sv
// Top level of the three-point temperature calibration core.
// Usage:
//   Send raw samples on req_* (valid/stall); a transfer happens when req_valid
//   is high and req_stall is low. One result per sample comes out on rsp_* in
//   order, with the same handshake, stalled by rsp_stall.
//   csr_write_enable writes csr_wdata to calibration register csr_index
//   (0..5: point1 raw/ref, point2 raw/ref, point3 raw/ref); other indexes are
//   dropped. Write only while the core holds no samples.
// Throughput and stages:
//   One sample per cycle while rsp_stall is low. Between the input transfer
//   and rsp_valid lie five front stages (differences, two multiply levels,
//   numerator sum, magnitudes), seventeen division cells (overflow bit plus
//   sixteen quotient bits) and the result register.
// Reset:
//   Synchronous, active high. Empties the pipeline and loads the calibration
//   points 10.00, 40.00 and 80.00 degrees as identity pairs.
// Stall:
//   A stalled result holds; each stage keeps accepting while a bubble ahead
//   of it exists, so the pipeline compacts before req_stall rises.
`default_nettype none
module three_point_temperature_calibration_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [tpc_pkg::DataWidth-1:0] req_raw_temp,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [tpc_pkg::DataWidth-1:0]      rsp_calibrated_temp,
   output logic                               rsp_passthrough,
   output logic                               rsp_saturated,
   input  wire logic                          csr_write_enable,
   input  wire logic [tpc_pkg::IdxWidth-1:0]  csr_index,
   input  wire logic [tpc_pkg::DataWidth-1:0] csr_wdata
);
   import tpc_pkg::*;

   cal_type cal_ff;

   // calibration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff.point1_raw <= RESET_POINT1;
         cal_ff.point1_ref <= RESET_POINT1;
         cal_ff.point2_raw <= RESET_POINT2;
         cal_ff.point2_ref <= RESET_POINT2;
         cal_ff.point3_raw <= RESET_POINT3;
         cal_ff.point3_ref <= RESET_POINT3;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_POINT1_RAW: cal_ff.point1_raw <= csr_wdata;
            REG_POINT1_REF: cal_ff.point1_ref <= csr_wdata;
            REG_POINT2_RAW: cal_ff.point2_raw <= csr_wdata;
            REG_POINT2_REF: cal_ff.point2_ref <= csr_wdata;
            REG_POINT3_RAW: cal_ff.point3_raw <= csr_wdata;
            REG_POINT3_REF: cal_ff.point3_ref <= csr_wdata;
            default: ;
         endcase
      end
   end

   localparam int NumCells = QuoWidth;

   logic         front_ready;
   logic         cv [NumCells+1];
   logic         cr [NumCells+1];
   div_item_type ci [NumCells+1];

   assign req_stall = !front_ready;

   tpc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_raw    (req_raw_temp),
      .cal       (cal_ff),
      .out_valid (cv[0]),
      .out_ready (cr[0]),
      .out_item  (ci[0])
   );

   // chain of division cells, overflow bit first, then MSB to LSB
   for (genvar g = 0; g < NumCells; g++) begin : g_cell
      tpc_div_cell #(.Shift(NumCells - 1 - g)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (cv[g]),
         .in_ready  (cr[g]),
         .in_item   (ci[g]),
         .out_valid (cv[g+1]),
         .out_ready (cr[g+1]),
         .out_item  (ci[g+1])
      );
   end

   tpc_back u_back (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (cv[NumCells]),
      .in_ready            (cr[NumCells]),
      .in_item             (ci[NumCells]),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_calibrated_temp (rsp_calibrated_temp),
      .rsp_passthrough     (rsp_passthrough),
      .rsp_saturated       (rsp_saturated)
   );
endmodule
`default_nettype wire

// File: hw/rtl/tpc_front.sv
// Five-stage front end: differences, products, numerator sum and magnitudes.
`default_nettype none
module tpc_front (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   output logic                              in_ready,
   input  wire logic [tpc_pkg::DataWidth-1:0] in_raw,
   input  wire tpc_pkg::cal_type             cal,
   output logic                              out_valid,
   input  wire logic                         out_ready,
   output tpc_pkg::div_item_type             out_item
);
   import tpc_pkg::*;

   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic r1, r2, r3, r4, r5;

   assign r5 = !v5_ff || out_ready;
   assign r4 = !v4_ff || r5;
   assign r3 = !v3_ff || r4;
   assign r2 = !v2_ff || r3;
   assign r1 = !v1_ff || r2;
   assign in_ready = r1;

   // stage 1
   logic signed [16:0] xa_ff, xb_ff, xc_ff, ab_ff, ac_ff, bc_ff;
   logic signed [15:0] ya_ff, yb_ff, yc_ff;
   logic        pass1_ff;
   logic [15:0] raw1_ff;
   // stage 2
   logic signed [32:0] p1_ff, p2_ff, p3_ff;
   logic signed [33:0] q1_ff, q2_ff, q3_ff, dd_ff;
   logic signed [16:0] bc2_ff;
   logic        pass2_ff;
   logic [15:0] raw2_ff;
   // stage 3
   logic signed [66:0] t1_ff, t2_ff, t3_ff;
   logic signed [50:0] d3_ff;
   logic        pass3_ff;
   logic [15:0] raw3_ff;
   // stage 4
   logic signed [68:0] n4_ff;
   logic signed [50:0] d4_ff;
   logic        pass4_ff;
   logic [15:0] raw4_ff;
   // stage 5
   div_item_type item5_ff;

   logic signed [16:0] x_ext, a_ext, b_ext, c_ext;
   assign x_ext = {in_raw[15], in_raw};
   assign a_ext = {cal.point1_raw[15], cal.point1_raw};
   assign b_ext = {cal.point2_raw[15], cal.point2_raw};
   assign c_ext = {cal.point3_raw[15], cal.point3_raw};

   logic [68:0] mag_n;
   logic [50:0] mag_d;
   assign mag_n = n4_ff[68] ? 69'(-n4_ff) : 69'(n4_ff);
   assign mag_d = d4_ff[50] ? 51'(-d4_ff) : 51'(d4_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         if (r1) v1_ff <= in_valid;
         if (r2) v2_ff <= v1_ff;
         if (r3) v3_ff <= v2_ff;
         if (r4) v4_ff <= v3_ff;
         if (r5) v5_ff <= v4_ff;
      end
      if (r1) begin
         xa_ff    <= x_ext - a_ext;
         xb_ff    <= x_ext - b_ext;
         xc_ff    <= x_ext - c_ext;
         ab_ff    <= a_ext - b_ext;
         ac_ff    <= a_ext - c_ext;
         bc_ff    <= b_ext - c_ext;
         ya_ff    <= cal.point1_ref;
         yb_ff    <= cal.point2_ref;
         yc_ff    <= cal.point3_ref;
         pass1_ff <= (a_ext == b_ext) || (a_ext == c_ext) || (b_ext == c_ext);
         raw1_ff  <= in_raw;
      end
      if (r2) begin
         p1_ff    <= ya_ff * xb_ff;
         p2_ff    <= yb_ff * xa_ff;
         p3_ff    <= yc_ff * xa_ff;
         q1_ff    <= xc_ff * bc_ff;
         q2_ff    <= xc_ff * ac_ff;
         q3_ff    <= xb_ff * ab_ff;
         dd_ff    <= ab_ff * ac_ff;
         bc2_ff   <= bc_ff;
         pass2_ff <= pass1_ff;
         raw2_ff  <= raw1_ff;
      end
      if (r3) begin
         t1_ff    <= p1_ff * q1_ff;
         t2_ff    <= p2_ff * q2_ff;
         t3_ff    <= p3_ff * q3_ff;
         d3_ff    <= dd_ff * bc2_ff;
         pass3_ff <= pass2_ff;
         raw3_ff  <= raw2_ff;
      end
      if (r4) begin
         n4_ff    <= 69'(t1_ff) - 69'(t2_ff) + 69'(t3_ff);
         d4_ff    <= d3_ff;
         pass4_ff <= pass3_ff;
         raw4_ff  <= raw3_ff;
      end
      if (r5) begin
         // dividend 2|N| + |D| over divisor 2|D| rounds half away from zero
         item5_ff.rem  <= {mag_n[67:0], 1'b0} + 69'(mag_d);
         item5_ff.dvs  <= {mag_d, 1'b0};
         item5_ff.quo  <= '0;
         item5_ff.neg  <= n4_ff[68] ^ d4_ff[50];
         item5_ff.pass <= pass4_ff;
         item5_ff.raw  <= raw4_ff;
      end
   end

   assign out_valid = v5_ff;
   assign out_item  = item5_ff;
endmodule
`default_nettype wire

// File: hw/rtl/tpc_div_cell.sv
// One restoring-division cell: try one shifted divisor, keep one quotient bit.
`default_nettype none
module tpc_div_cell #(
   parameter int Shift = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire tpc_pkg::div_item_type in_item,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output tpc_pkg::div_item_type      out_item
);
   import tpc_pkg::*;

   logic         valid_ff;
   div_item_type item_ff, item_in;
   logic [RemWidth-1:0] trial;

   assign in_ready = !valid_ff || out_ready;
   assign trial    = RemWidth'(in_item.dvs) << Shift;

   always_comb begin
      item_in = in_item;
      if (in_item.rem >= trial) begin
         item_in.rem        = in_item.rem - trial;
         item_in.quo[Shift] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) item_ff <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;
endmodule
`default_nettype wire

// File: hw/rtl/tpc_back.sv
// Output stage: rounding result selection, saturation and the result register.
`default_nettype none
module tpc_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire tpc_pkg::div_item_type         in_item,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [tpc_pkg::DataWidth-1:0]      rsp_calibrated_temp,
   output logic                               rsp_passthrough,
   output logic                               rsp_saturated
);
   import tpc_pkg::*;

   logic                 valid_ff;
   logic [DataWidth-1:0] temp_ff, temp_in;
   logic                 pass_ff, sat_ff, sat_in;
   logic [15:0]          q;

   assign in_ready = !valid_ff || !rsp_stall;
   assign q        = in_item.quo[15:0];

   always_comb begin
      temp_in = q;
      sat_in  = 1'b0;
      if (in_item.pass) begin
         temp_in = in_item.raw;
      end else if (!in_item.neg) begin
         if (in_item.quo[16] || q[15]) begin
            temp_in = SAT_MAX;
            sat_in  = 1'b1;
         end
      end else begin
         if (in_item.quo[16] || (q > 16'h8000)) begin
            temp_in = SAT_MIN;
            sat_in  = 1'b1;
         end else begin
            temp_in = -q;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         temp_ff <= temp_in;
         pass_ff <= in_item.pass;
         sat_ff  <= sat_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_calibrated_temp = temp_ff;
   assign rsp_passthrough     = pass_ff;
   assign rsp_saturated       = sat_ff;
endmodule
`default_nettype wire

// File: hw/rtl/tpc_checker.sv
// Port-level checker for the calibration core and its bind.
`default_nettype none
module tpc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_calibrated_temp,
   input wire logic        rsp_passthrough,
   input wire logic        rsp_saturated
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_calibrated_temp))
      else $error("stalled result changed");

   a_pass_nosat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_passthrough |-> !rsp_saturated)
      else $error("passthrough result flagged saturated");

   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_calibrated_temp == 16'h7FFF || rsp_calibrated_temp == 16'h8000)
      else $error("saturated result off the rail");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");
endmodule

bind three_point_temperature_calibration_core tpc_checker u_tpc_checker (
   .clock               (clock),
   .reset               (reset),
   .rsp_valid           (rsp_valid),
   .rsp_stall           (rsp_stall),
   .rsp_calibrated_temp (rsp_calibrated_temp),
   .rsp_passthrough     (rsp_passthrough),
   .rsp_saturated       (rsp_saturated)
);
`default_nettype wire

// File: test/tb_three_point_temperature_calibration_core.sv
// Testbench for the three-point temperature calibration core: directed table plus random stream.
module tb_three_point_temperature_calibration_core;
   import tpc_pkg::*;

   // Indexes past the register file; writes there must leave the points alone
   localparam logic [IdxWidth-1:0] REG_UNUSED_LO = 3'd6;
   localparam logic [IdxWidth-1:0] REG_UNUSED_HI = 3'd7;
   localparam int NumPoints     = 6;
   localparam int WatchdogLimit = 5000;

   typedef logic signed [DataWidth-1:0] sample_type;
   typedef sample_type cal_set_type [NumPoints];

   typedef struct {
      sample_type temp;
      logic       pass;
      logic       sat;
   } cal_result_type;

   // One row of the directed table: calibration set, raw sample and, where it
   // is obvious, the result typed in by hand
   typedef struct {
      int             set_id;
      sample_type     raw;
      logic           typed;
      cal_result_type want;
   } directed_row_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   sample_type req_raw_temp = '0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [DataWidth-1:0] rsp_calibrated_temp;
   logic       rsp_passthrough;
   logic       rsp_saturated;
   logic       csr_write_enable = 1'b0;
   logic [IdxWidth-1:0]  csr_index = '0;
   logic [DataWidth-1:0] csr_wdata = '0;

   cal_set_type    cal_points;          // predictor copy of the calibration registers
   cal_result_type pending_results[$];  // calibrated results still owed by the core
   logic           typed_valid[$];      // hand-typed result waiting alongside, if any
   cal_result_type typed_results[$];
   int             error_count = 0;
   int             idle_count  = 0;
   bit             bursts_on   = 1'b1;  // random idling on both sides
   bit             long_hold   = 1'b0;  // ask the receiver for one long hold-off
   bit             have_typed  = 1'b0;
   cal_result_type next_typed;

   three_point_temperature_calibration_core DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Exact Lagrange evaluation: one numerator over the common denominator,
   // rounded half away from zero, clamped to 16 bits
   function automatic cal_result_type calibrate(input sample_type raw);
      logic signed [95:0] x, a, ya, b, yb, c, yc, num, den;
      logic [95:0] num_mag, den_mag, quo;
      logic neg;
      cal_result_type res;
      x  = raw;
      a  = cal_points[0]; ya = cal_points[1];
      b  = cal_points[2]; yb = cal_points[3];
      c  = cal_points[4]; yc = cal_points[5];
      res.sat = 1'b0;
      if (a == b || a == c || b == c) begin
         // coinciding points: hand the raw sample back untouched
         res.temp = raw;
         res.pass = 1'b1;
         return res;
      end
      res.pass = 1'b0;
      num = ya * (x - b) * (x - c) * (b - c) - yb * (x - a) * (x - c) * (a - c)
            + yc * (x - a) * (x - b) * (a - b);
      den = (a - b) * (a - c) * (b - c);
      neg = (num < 0) ^ (den < 0);
      num_mag = (num < 0) ? -num : num;
      den_mag = (den < 0) ? -den : den;
      quo = (2 * num_mag + den_mag) / (2 * den_mag);
      if (!neg) begin
         if (quo > 32767) begin res.temp = SAT_MAX; res.sat = 1'b1; end
         else res.temp = sample_type'(quo);
      end else begin
         if (quo > 32768) begin res.temp = SAT_MIN; res.sat = 1'b1; end
         else res.temp = sample_type'(-quo);
      end
      return res;
   endfunction

   // Predict on every input transfer, check every output transfer, watch for hangs
   always @(posedge clock) begin
      cal_result_type want;
      logic           is_typed;
      cal_result_type typed_want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            pending_results.push_back(calibrate(req_raw_temp));
            typed_valid.push_back(have_typed);
            typed_results.push_back(next_typed);
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $display("%0t: unexpected result %0d pass %0b sat %0b", $time,
                        $signed(rsp_calibrated_temp), rsp_passthrough, rsp_saturated);
               error_count++;
            end else begin
               want       = pending_results.pop_front();
               is_typed   = typed_valid.pop_front();
               typed_want = typed_results.pop_front();
               // a hand-typed row must also agree with the predictor
               if (is_typed && (typed_want.temp != want.temp || typed_want.pass != want.pass
                                || typed_want.sat != want.sat)) begin
                  $display("%0t: table row expected %0d/%0b/%0b, predictor %0d/%0b/%0b",
                           $time, typed_want.temp, typed_want.pass, typed_want.sat,
                           want.temp, want.pass, want.sat);
                  error_count++;
               end
               if (rsp_calibrated_temp != want.temp) begin
                  $display("%0t: calibrated_temp expected %0d actual %0d", $time,
                           want.temp, $signed(rsp_calibrated_temp));
                  error_count++;
               end
               if (rsp_passthrough != want.pass) begin
                  $display("%0t: passthrough expected %0b actual %0b", $time,
                           want.pass, rsp_passthrough);
                  error_count++;
               end
               if (rsp_saturated != want.sat) begin
                  $display("%0t: saturated expected %0b actual %0b", $time,
                           want.sat, rsp_saturated);
                  error_count++;
               end
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_count = 0;
         else if (req_valid || pending_results.size() != 0) idle_count++;
         if (idle_count >= WatchdogLimit) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   // Receiver: random stall bursts, plus one long hold-off on request
   always @(negedge clock) begin
      static int stall_left = 0;
      static int hold_left  = 0;
      logic next_stall;
      if (long_hold && hold_left == 0) begin
         hold_left = 300;
         long_hold = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         next_stall = 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         next_stall = 1'b1;
      end else if (bursts_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 7);
         next_stall = 1'b1;
      end else begin
         next_stall = 1'b0;
      end
      rsp_stall <= next_stall;
   end

   // Offer one sample; return at the edge where it is transferred
   task automatic send_sample(input sample_type raw, input logic typed,
                              input cal_result_type want);
      @(negedge clock);
      if (bursts_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      have_typed    = typed;
      next_typed    = want;
      req_valid    <= 1'b1;
      req_raw_temp <= raw;
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid, then hold until the core owes nothing
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending_results.size() == 0);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(input logic [IdxWidth-1:0] idx, input sample_type value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
      if (idx < NumPoints) cal_points[idx] = value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Load a whole calibration set, with junk to the unused indexes before and after
   task automatic load_points(input cal_set_type pts);
      write_reg(REG_UNUSED_LO, sample_type'($urandom));
      write_reg(REG_POINT1_RAW, pts[0]);
      write_reg(REG_POINT1_REF, pts[1]);
      write_reg(REG_POINT2_RAW, pts[2]);
      write_reg(REG_POINT2_REF, pts[3]);
      write_reg(REG_POINT3_RAW, pts[4]);
      write_reg(REG_POINT3_REF, pts[5]);
      write_reg(REG_UNUSED_HI, sample_type'($urandom));
   endtask

   function automatic sample_type rand_sample();
      return sample_type'($urandom);
   endfunction

   function automatic cal_set_type rand_points();
      cal_set_type pts;
      int style;
      style = $urandom_range(0, 7);
      foreach (pts[i]) pts[i] = rand_sample();
      if (style <= 2) begin
         // realistic: well-spread raw points, references close to them
         pts[0] = sample_type'($urandom_range(0, 4000)) - 2000;
         pts[2] = pts[0] + sample_type'($urandom_range(1, 5000));
         pts[4] = pts[2] + sample_type'($urandom_range(1, 5000));
         pts[1] = pts[0] + sample_type'($urandom_range(0, 400)) - 200;
         pts[3] = pts[2] + sample_type'($urandom_range(0, 400)) - 200;
         pts[5] = pts[4] + sample_type'($urandom_range(0, 400)) - 200;
      end else if (style == 3) begin
         // two raw points coincide
         case ($urandom_range(0, 2))
            0: pts[2] = pts[0];
            1: pts[4] = pts[0];
            default: pts[4] = pts[2];
         endcase
      end else if (style == 4) begin
         // packed raw points give steep curves and frequent clamping
         pts[0] = rand_sample();
         pts[2] = pts[0] + sample_type'($urandom_range(1, 3));
         pts[4] = pts[2] + sample_type'($urandom_range(1, 3));
      end
      return pts;
   endfunction

   function automatic sample_type sample_near(input cal_set_type pts);
      case ($urandom_range(0, 3))
         0: return rand_sample();
         1: return sample_type'($urandom_range(0, 16) - 8) + pts[2 * $urandom_range(0, 2)];
         2: return sample_type'($urandom_range(0, 20000)) - 10000;
         default: return ($urandom_range(0, 1)) ? SAT_MAX - sample_type'($urandom_range(0, 3))
                                                : SAT_MIN + sample_type'($urandom_range(0, 3));
      endcase
   endfunction

   cal_set_type      point_sets[5];
   directed_row_type directed[$];

   initial begin
      cal_set_type    pts;
      cal_result_type none;
      int             cur_set;
      int             n_items;
      none = '{temp: '0, pass: 1'b0, sat: 1'b0};

      // Reset values form identity pairs, so the curve is y = x
      point_sets[0] = '{RESET_POINT1, RESET_POINT1, RESET_POINT2, RESET_POINT2,
                        RESET_POINT3, RESET_POINT3};
      // point 1 and point 2 share a raw reading: raw samples pass through
      point_sets[1] = '{16'sd100, 16'sd0, 16'sd100, 16'sd5, 16'sd300, 16'sd7};
      // extreme raw points and references
      point_sets[2] = '{SAT_MIN, SAT_MAX, 16'sd0, SAT_MIN, SAT_MAX, SAT_MAX};
      // adjacent raw points with opposite extreme references: steep parabola
      point_sets[3] = '{16'sd0, SAT_MIN, 16'sd1, SAT_MAX, 16'sd2, SAT_MIN};
      // small even spacing, quarters show up between the points
      point_sets[4] = '{16'sd0, 16'sd0, 16'sd2, 16'sd1, 16'sd4, 16'sd0};

      directed = '{
         '{0, 16'sd0,     1'b1, '{16'sd0,     1'b0, 1'b0}},
         '{0, SAT_MAX,    1'b1, '{SAT_MAX,    1'b0, 1'b0}},
         '{0, SAT_MIN,    1'b1, '{SAT_MIN,    1'b0, 1'b0}},
         '{0, 16'sd1000,  1'b1, '{16'sd1000,  1'b0, 1'b0}},
         '{0, -16'sd1,    1'b1, '{-16'sd1,    1'b0, 1'b0}},
         '{1, SAT_MAX,    1'b1, '{SAT_MAX,    1'b1, 1'b0}},
         '{1, SAT_MIN,    1'b1, '{SAT_MIN,    1'b1, 1'b0}},
         '{1, 16'sd100,   1'b1, '{16'sd100,   1'b1, 1'b0}},
         '{1, -16'sd1234, 1'b1, '{-16'sd1234, 1'b1, 1'b0}},
         '{2, SAT_MIN,    1'b1, '{SAT_MAX,    1'b0, 1'b0}},
         '{2, SAT_MAX,    1'b1, '{SAT_MAX,    1'b0, 1'b0}},
         '{2, 16'sd0,     1'b1, '{SAT_MIN,    1'b0, 1'b0}},
         '{2, 16'sd12345, 1'b0, none},
         '{3, 16'sd100,   1'b0, none},
         '{3, -16'sd100,  1'b0, none},
         '{3, 16'sd1,     1'b1, '{SAT_MAX,    1'b0, 1'b0}},
         '{3, SAT_MAX,    1'b0, none},
         '{4, 16'sd1,     1'b0, none},
         '{4, 16'sd3,     1'b0, none},
         '{4, -16'sd1,    1'b0, none},
         '{4, 16'sd2,     1'b1, '{16'sd1,     1'b0, 1'b0}}
      };

      cal_points = point_sets[0];
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed table; switch calibration only once the core is empty
      cur_set = 0;
      foreach (directed[i]) begin
         if (directed[i].set_id != cur_set) begin
            drain();
            cur_set = directed[i].set_id;
            load_points(point_sets[cur_set]);
         end
         send_sample(directed[i].raw, directed[i].typed, directed[i].want);
      end
      have_typed = 1'b0;
      drain();

      // Random phases; phase 2 fills the pipe behind a long receiver hold-off,
      // the last phase runs with no idling at all
      for (int phase = 0; phase < 12; phase++) begin
         pts = rand_points();
         load_points(pts);
         if (phase == 2) long_hold = 1'b1;
         if (phase == 11) bursts_on = 1'b0;
         n_items = 100;
         for (int k = 0; k < n_items; k++) send_sample(sample_near(pts), 1'b0, none);
         drain();
      end

      repeat (30) @(posedge clock);
      if (error_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// File: filelist.f
hw/rtl/tpc_pkg.sv
hw/rtl/tpc_front.sv
hw/rtl/tpc_div_cell.sv
hw/rtl/tpc_back.sv
hw/rtl/three_point_temperature_calibration_core.sv
hw/rtl/tpc_checker.sv
test/tb_three_point_temperature_calibration_core.sv
